// ===== sv/lrutlb_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, op codes and command type for the lru translation buffer
// no dependencies

package lrutlb_pkg;

  localparam int ENTRIES = 8;
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 20;
  localparam int COUNT_W = 32;
  localparam int OP_W    = 2;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic load_in;
    logic exec;
  } cmd_t;

endpackage

// ===== sv/lrutlb_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and result beats
// depends on lrutlb_pkg

interface lrutlb_in_if;
  logic                           valid;
  logic                           ready;
  logic [lrutlb_pkg::OP_W-1:0]    op;
  logic [lrutlb_pkg::PAGE_W-1:0]  page_number;
  logic [lrutlb_pkg::FRAME_W-1:0] frame_number;

  modport source (output valid, output op, output page_number, output frame_number,
                  input ready);
  modport sink (input valid, input op, input page_number, input frame_number,
                output ready);
endinterface

interface lrutlb_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [lrutlb_pkg::FRAME_W-1:0] found_frame;
  logic [lrutlb_pkg::COUNT_W-1:0] hit_count;
  logic [lrutlb_pkg::COUNT_W-1:0] miss_count;

  modport source (output valid, output hit, output found_frame, output hit_count,
                  output miss_count, input ready);
  modport sink (input valid, input hit, input found_frame, input hit_count,
                input miss_count, output ready);
endinterface

// ===== sv/lrutlb_ctrl.sv =====
`timescale 1ns / 1ps
// controller: request capture, execute slot and result valid
// depends on lrutlb_pkg

module lrutlb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lrutlb_pkg::cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.load_in   = 1'b0;
    cmd.exec      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.exec)
    else $error("result overwritten while stalled");

  // a captured beat enters the execute state in the next cycle
  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> (state_r == S_EXEC))
    else $error("capture did not enter execute");

  // execute always presents a result
  a_exec_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("execute without result");
`endif

endmodule

// ===== sv/lrutlb_dp.sv =====
`timescale 1ns / 1ps
// datapath: entry store, tag compare, lru ranks, counters and result register
// depends on lrutlb_pkg

module lrutlb_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lrutlb_pkg::cmd_t               cmd,
  input  logic [lrutlb_pkg::OP_W-1:0]    in_op,
  input  logic [lrutlb_pkg::PAGE_W-1:0]  in_page,
  input  logic [lrutlb_pkg::FRAME_W-1:0] in_frame,
  output logic                           res_hit,
  output logic [lrutlb_pkg::FRAME_W-1:0] res_frame,
  output logic [lrutlb_pkg::COUNT_W-1:0] res_hits,
  output logic [lrutlb_pkg::COUNT_W-1:0] res_misses
);

  localparam int N  = lrutlb_pkg::ENTRIES;
  localparam int IW = lrutlb_pkg::IDX_W;
  localparam int CW = lrutlb_pkg::CNT_W;
  localparam int PW = lrutlb_pkg::PAGE_W;
  localparam int FW = lrutlb_pkg::FRAME_W;
  localparam int KW = lrutlb_pkg::COUNT_W;
  localparam logic [IW-1:0] RANK_LAST = IW'(N - 1);
  localparam logic [KW-1:0] COUNT_MAX = '1;

  // captured request
  logic [lrutlb_pkg::OP_W-1:0] op_r;
  logic [PW-1:0]               page_r;
  logic [FW-1:0]               frame_r;

  // entry store
  logic [PW-1:0] ent_page_r  [N];
  logic [FW-1:0] ent_frame_r [N];
  logic [N-1:0]  valid_r, valid_nxt;
  logic [IW-1:0] rank_r [N];
  logic [IW-1:0] rank_nxt [N];
  logic [KW-1:0] hits_r, hits_nxt;
  logic [KW-1:0] misses_r, misses_nxt;

  // result register
  logic          res_hit_r;
  logic [FW-1:0] res_frame_r;
  logic [KW-1:0] res_hits_r;
  logic [KW-1:0] res_misses_r;

  logic [N-1:0]  match;
  logic          hit_any;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] lru_idx;
  logic [CW-1:0] used_cnt;
  logic          full;
  logic [IW-1:0] tgt_idx;
  logic [IW-1:0] old_rank;
  logic          is_lookup, is_insert, is_clear;
  logic          do_touch;
  logic          res_hit_nxt;
  logic [FW-1:0] res_frame_nxt;

  assign is_lookup = (op_r == lrutlb_pkg::OP_LOOKUP);
  assign is_insert = (op_r == lrutlb_pkg::OP_INSERT);
  assign is_clear  = (op_r == lrutlb_pkg::OP_CLEAR);

  // parallel tag compare and entry scans
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    used_cnt = '0;
    for (int i = N - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && (ent_page_r[i] == page_r);
      if (match[i]) begin
        hit_idx = IW'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
    for (int i = 0; i < N; i++) begin
      if (rank_r[i] == RANK_LAST) begin
        lru_idx = IW'(i);
      end
      used_cnt = used_cnt + CW'(valid_r[i]);
    end
  end

  assign hit_any = |match;
  assign full    = &valid_r;

  always_comb begin
    if (hit_any) begin
      tgt_idx  = hit_idx;
      old_rank = rank_r[hit_idx];
    end else if (!full) begin
      tgt_idx  = free_idx;
      old_rank = used_cnt[IW-1:0];
    end else begin
      tgt_idx  = lru_idx;
      old_rank = rank_r[lru_idx];
    end
  end

  assign do_touch = cmd.exec && ((is_lookup && hit_any) || is_insert);

  // recency update and fill
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_touch) begin
        if (IW'(i) == tgt_idx) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < old_rank)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
    if (cmd.exec && is_insert) begin
      valid_nxt[tgt_idx] = 1'b1;
    end
  end

  // saturating counters
  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (cmd.exec) begin
      if (is_lookup && hit_any && (hits_r != COUNT_MAX)) begin
        hits_nxt = hits_r + 1'b1;
      end
      if (is_lookup && !hit_any && (misses_r != COUNT_MAX)) begin
        misses_nxt = misses_r + 1'b1;
      end
      if (is_clear) begin
        hits_nxt   = '0;
        misses_nxt = '0;
      end
    end
  end

  assign res_hit_nxt   = (is_lookup || is_insert) && hit_any;
  assign res_frame_nxt = (is_lookup && hit_any) ? ent_frame_r[hit_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r  <= valid_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= in_op;
      page_r  <= in_page;
      frame_r <= in_frame;
    end
    if (cmd.exec && is_insert) begin
      ent_page_r[tgt_idx]  <= page_r;
      ent_frame_r[tgt_idx] <= frame_r;
    end
    if (cmd.exec) begin
      res_hit_r    <= res_hit_nxt;
      res_frame_r  <= res_frame_nxt;
      res_hits_r   <= hits_nxt;
      res_misses_r <= misses_nxt;
    end
  end

  assign res_hit    = res_hit_r;
  assign res_frame  = res_frame_r;
  assign res_hits   = res_hits_r;
  assign res_misses = res_misses_r;

`ifndef SYNTHESIS
  // entries are never invalidated
  a_valid_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_nxt) >= $countones(valid_r)))
    else $error("entry count dropped");

  // a miss never reports a frame
  a_miss_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !hit_any) |=> (res_frame_r == '0))
    else $error("frame reported on miss");

  // clear shows zero counters in its own result
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && is_clear) |=> ((res_hits_r == '0) && (res_misses_r == '0)))
    else $error("clear result not zero");
`endif

endmodule

// ===== sv/lru_tlb_lookup_insert_top.sv =====
`timescale 1ns / 1ps
// Eight-entry fully associative translation buffer with lru replacement and
// saturating hit and miss counters. Each request beat (lookup, insert or
// clear) yields one result beat: the request is captured, then the parallel
// tag compare, rank update and result load follow. A new request is not
// taken until the previous one has executed. The execute step waits while
// a previous result is still held, and a new request is taken while a
// result waits. The buffer is empty after reset; no clearing pass is needed.
// depends on lrutlb_pkg, lrutlb_if, lrutlb_ctrl, lrutlb_dp

module lru_tlb_lookup_insert_top (
  input  logic           clk,
  input  logic           rst_n,
  lrutlb_in_if.sink      in_chan,
  lrutlb_out_if.source   out_chan
);

  lrutlb_pkg::cmd_t cmd;

  lrutlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  lrutlb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_chan.op),
    .in_page    (in_chan.page_number),
    .in_frame   (in_chan.frame_number),
    .res_hit    (out_chan.hit),
    .res_frame  (out_chan.found_frame),
    .res_hits   (out_chan.hit_count),
    .res_misses (out_chan.miss_count)
  );

endmodule

// ===== tb/tb_lru_tlb_lookup_insert_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for lru_tlb_lookup_insert_top: directed and random lookup,
// insert and clear beats, each result checked against a mirror of the lru buffer
// depends on lrutlb_pkg, lrutlb_if and the block rtl

module tb_lru_tlb_lookup_insert_top;

  localparam int ENTRIES = lrutlb_pkg::ENTRIES;
  localparam int PAGE_W  = lrutlb_pkg::PAGE_W;
  localparam int FRAME_W = lrutlb_pkg::FRAME_W;
  localparam int COUNT_W = lrutlb_pkg::COUNT_W;
  localparam int OP_W    = lrutlb_pkg::OP_W;
  localparam int IDX_W   = lrutlb_pkg::IDX_W;
  localparam logic [OP_W-1:0] OP_LOOKUP = lrutlb_pkg::OP_LOOKUP;
  localparam logic [OP_W-1:0] OP_INSERT = lrutlb_pkg::OP_INSERT;
  localparam logic [OP_W-1:0] OP_CLEAR  = lrutlb_pkg::OP_CLEAR;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOT_PAGES   = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 300;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic               hit;
    logic [FRAME_W-1:0] found_frame;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;
  } tlb_result_t;

  class tlb_mirror;
    logic [PAGE_W-1:0]  page_tag[ENTRIES];
    logic [FRAME_W-1:0] frame_of[ENTRIES];
    logic               live[ENTRIES];
    logic [IDX_W-1:0]   rank[ENTRIES];
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] misses;
    tlb_result_t        awaited[$];
    int                 mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        page_tag[i] = '0;
        frame_of[i] = '0;
        live[i]     = 1'b0;
        rank[i]     = '0;
      end
      hits       = '0;
      misses     = '0;
      mismatches = 0;
    endfunction

    function int find_entry(logic [PAGE_W-1:0] page);
      for (int i = 0; i < ENTRIES; i++) begin
        if (live[i] && page_tag[i] == page) return i;
      end
      return -1;
    endfunction

    // entries younger than old_rank age by one, idx becomes most recent
    function void promote(int idx, int old_rank);
      for (int i = 0; i < ENTRIES; i++) begin
        if (i != idx && live[i] && rank[i] < old_rank) rank[i] = rank[i] + 1'b1;
      end
      rank[idx] = '0;
    endfunction

    function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void apply_request(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
                                logic [FRAME_W-1:0] frame);
      tlb_result_t r;
      int idx;
      int used;
      int victim;
      r.hit         = 1'b0;
      r.found_frame = '0;
      case (op)
        OP_LOOKUP: begin
          idx = find_entry(page);
          if (idx >= 0) begin
            r.hit         = 1'b1;
            r.found_frame = frame_of[idx];
            promote(idx, int'(rank[idx]));
            hits = bump(hits);
          end else begin
            misses = bump(misses);
          end
        end
        OP_INSERT: begin
          idx = find_entry(page);
          if (idx >= 0) begin
            r.hit         = 1'b1;
            frame_of[idx] = frame;
            promote(idx, int'(rank[idx]));
          end else begin
            used   = 0;
            victim = -1;
            for (int i = 0; i < ENTRIES; i++) begin
              if (live[i]) used++;
              else if (victim < 0) victim = i;
            end
            // full buffer: replace the least recent entry
            if (victim < 0) begin
              victim = 0;
              for (int i = 0; i < ENTRIES; i++) begin
                if (rank[i] == ENTRIES - 1) victim = i;
              end
              used = int'(rank[victim]);
            end
            live[victim]     = 1'b1;
            page_tag[victim] = page;
            frame_of[victim] = frame;
            promote(victim, used);
          end
        end
        OP_CLEAR: begin
          hits   = '0;
          misses = '0;
        end
        default: begin
        end
      endcase
      r.hit_count  = hits;
      r.miss_count = misses;
      awaited.push_back(r);
    endfunction

    function void check_result(tlb_result_t got);
      tlb_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result beat with nothing expected: hit %0b frame %h hits %0d misses %0d",
                   got.hit, got.found_frame, got.hit_count, got.miss_count);
        return;
      end
      want = awaited.pop_front();
      if (got.hit !== want.hit || got.found_frame !== want.found_frame ||
          got.hit_count !== want.hit_count || got.miss_count !== want.miss_count) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch at %0t: expected hit %0b frame %h hits %0d misses %0d",
                   $realtime, want.hit, want.found_frame, want.hit_count, want.miss_count);
          $display("                 actual   hit %0b frame %h hits %0d misses %0d",
                   got.hit, got.found_frame, got.hit_count, got.miss_count);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic calm;
  int   results_seen;
  int   cycles;
  logic [PAGE_W-1:0] hot_pages[HOT_PAGES];
  tlb_mirror mirror = new();

  lrutlb_in_if  in_chan();
  lrutlb_out_if out_chan();

  lru_tlb_lookup_insert_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // request and result monitors
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      mirror.apply_request(in_chan.op, in_chan.page_number, in_chan.frame_number);
  end

  always @(posedge clk) begin
    tlb_result_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.hit         = out_chan.hit;
      got.found_frame = out_chan.found_frame;
      got.hit_count   = out_chan.hit_count;
      got.miss_count  = out_chan.miss_count;
      mirror.check_result(got);
      results_seen++;
    end
  end

  // result side: random backpressure plus one long hold-off
  initial begin
    logic held;
    held = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        out_chan.ready <= calm || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("tb_lru_tlb_lookup_insert_top: done, errors");
    $finish;
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
                           input logic [FRAME_W-1:0] frame);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.op           <= op;
    in_chan.page_number  <= page;
    in_chan.frame_number <= frame;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // mostly pages from a small churning set so hits, updates and evictions all occur
  task automatic send_random(input int count);
    int pick;
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) op = OP_LOOKUP;
      else if (pick < 88) op = OP_INSERT;
      else if (pick < 94) op = OP_CLEAR;
      else op = OP_UNUSED;
      if ($urandom_range(0, 49) == 0)
        hot_pages[$urandom_range(0, HOT_PAGES - 1)] = PAGE_W'($urandom());
      if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom());
      else page = hot_pages[$urandom_range(0, HOT_PAGES - 1)];
      send_beat(op, page, FRAME_W'($urandom()));
    end
  endtask

  // sampled away from the rising edge so the monitors have already run
  task automatic wait_drained();
    @(negedge clk);
    while (mirror.awaited.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst_n                <= 1'b0;
    calm                  = 1'b0;
    results_seen          = 0;
    in_chan.valid        <= 1'b0;
    in_chan.op           <= OP_LOOKUP;
    in_chan.page_number  <= '0;
    in_chan.frame_number <= '0;
    for (int i = 0; i < HOT_PAGES; i++) hot_pages[i] = PAGE_W'($urandom());
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty buffer, field extremes, update, unused op, clear, eviction
    send_beat(OP_LOOKUP, '0, '0);
    send_beat(OP_INSERT, '0, '1);
    send_beat(OP_INSERT, '1, '0);
    send_beat(OP_LOOKUP, '1, '1);
    send_beat(OP_LOOKUP, '0, '0);
    send_beat(OP_INSERT, '0, 20'h12345);
    send_beat(OP_LOOKUP, '0, '0);
    send_beat(OP_UNUSED, '0, '1);
    send_beat(OP_CLEAR, '1, '1);
    for (int k = 1; k <= 6; k++) send_beat(OP_INSERT, PAGE_W'(k), FRAME_W'(k * 16'h1111));
    send_beat(OP_INSERT, PAGE_W'(7), 20'hABCDE);
    send_beat(OP_LOOKUP, '1, '0);
    send_beat(OP_LOOKUP, '0, '0);
    send_beat(OP_LOOKUP, PAGE_W'(7), '0);
    send_beat(OP_CLEAR, '0, 20'h55555);
    send_beat(OP_LOOKUP, 20'hAAAAA, '0);

    send_random(700);
    calm = 1'b1;
    send_random(500);
    calm = 1'b0;
    in_chan.valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    send_random(730);
    in_chan.valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
      $display("tb_lru_tlb_lookup_insert_top: done, clean");
    else
      $display("tb_lru_tlb_lookup_insert_top: done, errors");
    $finish;
  end

endmodule
